// ----- hw/rtl/flh_pkg.sv -----
// -----------------------------------------------------------------------------
// flh_pkg: shared types and constants of the flame histogram plotter
// Beat layouts, configuration register map, pipeline state and fixed widths.
// -----------------------------------------------------------------------------
package flh_pkg;

  localparam int FIELD_W    = 10;
  localparam int WARM_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POINT_W    = 20;
  localparam int COLOR_W    = 17;
  localparam int RD_W       = 9;
  localparam int OUT_SUM_W  = 40;
  localparam int OUT_HIT_W  = 24;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = POINT_W + FIELD_W + 1;
  localparam int SCALED_W   = 32;
  localparam int PIX_W      = SCALED_W - FRAC_W;

  localparam logic [COLOR_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [WARM_W-1:0]  WARM_MAX = 8'hFF;

  localparam logic [FIELD_W-1:0] RST_ACTIVE_WIDTH  = 10'd512;
  localparam logic [FIELD_W-1:0] RST_ACTIVE_HEIGHT = 10'd512;
  localparam logic [FIELD_W-1:0] RST_VIEW_SCALE    = 10'd400;
  localparam logic [FIELD_W-1:0] RST_OFFSET_COL    = 10'd500;
  localparam logic [FIELD_W-1:0] RST_OFFSET_ROW    = 10'd500;
  localparam logic [WARM_W-1:0]  RST_WARMUP_ITEMS  = 8'd21;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 3'd0,
    CFG_ACTIVE_HEIGHT = 3'd1,
    CFG_VIEW_SCALE    = 3'd2,
    CFG_OFFSET_COL    = 3'd3,
    CFG_OFFSET_ROW    = 3'd4,
    CFG_WARMUP_ITEMS  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [FIELD_W-1:0] active_width;
    logic [FIELD_W-1:0] active_height;
    logic [FIELD_W-1:0] view_scale;
    logic [FIELD_W-1:0] offset_col;
    logic [FIELD_W-1:0] offset_row;
    logic [WARM_W-1:0]  warmup_items;
  } cfg_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic                      mode;
    logic                      start_of_run;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [COLOR_W-1:0]        color_index;
    logic [RD_W-1:0]           read_col;
    logic [RD_W-1:0]           read_row;
  } item_t;

  typedef struct packed {
    logic [OUT_SUM_W-1:0] red_sum;
    logic [OUT_SUM_W-1:0] green_sum;
    logic [OUT_SUM_W-1:0] blue_sum;
    logic [OUT_HIT_W-1:0] hit_count;
  } result_t;

  // mapper -> control
  typedef struct packed {
    logic               is_read;
    logic               plot_hit;
    logic               in_grid;
    logic [COLOR_W-1:0] color;
  } map_t;

  // control -> bin store
  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [COLOR_W-1:0] color;
  } bin_req_t;

endpackage

// ----- hw/rtl/flh_item_if.sv -----
// -----------------------------------------------------------------------------
// flh_item_if: plot/read item channel
// Valid/ready channel carrying one input item per beat.
// -----------------------------------------------------------------------------
interface flh_item_if import flh_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/flh_result_if.sv -----
// -----------------------------------------------------------------------------
// flh_result_if: bin read result channel
// Valid/ready channel carrying one bin's sums and hit count per beat.
// -----------------------------------------------------------------------------
interface flh_result_if import flh_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/flh_cfg_if.sv -----
// -----------------------------------------------------------------------------
// flh_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// -----------------------------------------------------------------------------
interface flh_cfg_if import flh_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/flh_cfg_regs.sv -----
// -----------------------------------------------------------------------------
// flh_cfg_regs: configuration register file
// Holds the view transform, active grid and warm-up registers.
// -----------------------------------------------------------------------------
module flh_cfg_regs import flh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  flh_cfg_if.sink cfg_i,
  output cfg_t cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.idx)
        CFG_ACTIVE_WIDTH:  cfg_d.active_width  = cfg_i.data.wdata[FIELD_W-1:0];
        CFG_ACTIVE_HEIGHT: cfg_d.active_height = cfg_i.data.wdata[FIELD_W-1:0];
        CFG_VIEW_SCALE:    cfg_d.view_scale    = cfg_i.data.wdata[FIELD_W-1:0];
        CFG_OFFSET_COL:    cfg_d.offset_col    = cfg_i.data.wdata[FIELD_W-1:0];
        CFG_OFFSET_ROW:    cfg_d.offset_row    = cfg_i.data.wdata[FIELD_W-1:0];
        CFG_WARMUP_ITEMS:  cfg_d.warmup_items  = cfg_i.data.wdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_width  <= RST_ACTIVE_WIDTH;
      cfg_q.active_height <= RST_ACTIVE_HEIGHT;
      cfg_q.view_scale    <= RST_VIEW_SCALE;
      cfg_q.offset_col    <= RST_OFFSET_COL;
      cfg_q.offset_row    <= RST_OFFSET_ROW;
      cfg_q.warmup_items  <= RST_WARMUP_ITEMS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hw/rtl/flh_mapper.sv -----
// -----------------------------------------------------------------------------
// flh_mapper: final transform, warm-up count and bin address
// Registers the scaled point on accept, then offsets, clips and forms the
// linear bin address for either a plot or a read item.
// -----------------------------------------------------------------------------
module flh_mapper import flh_pkg::*; #(
  parameter int GRID_WIDTH  = 512,
  parameter int GRID_HEIGHT = 512,
  parameter int ADDR_W      = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  item_t             item_i,
  input  cfg_t              cfg_i,
  output map_t              map_o,
  output logic [ADDR_W-1:0] addr_o
);

  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);

  logic [WARM_W-1:0]        items_q, items_d;
  logic [WARM_W-1:0]        run_idx;
  logic                     is_read_q;
  logic                     keep_q;
  logic signed [PROD_W-1:0] prod_x_q;
  logic signed [PROD_W-1:0] prod_y_q;
  logic [COLOR_W-1:0]       color_q;
  logic [RD_W-1:0]          read_col_q;
  logic [RD_W-1:0]          read_row_q;

  logic [PIX_W:0]   x_pix, y_pix;
  logic [PIX_W-1:0] col_sel, row_sel;
  logic             read_in_grid;

  // {on grid, pixel index}
  function automatic logic [PIX_W:0] to_pixel(
    input logic signed [PROD_W-1:0] prod,
    input logic [FIELD_W-1:0]       offset,
    input logic [FIELD_W-1:0]       active,
    input logic [PIX_W-1:0]         grid
  );
    logic signed [SCALED_W-1:0] p;
    logic [PIX_W-1:0]           lim;
    logic [PIX_W-1:0]           idx;
    p   = SCALED_W'(prod) + $signed({6'b0, offset, 16'b0});
    lim = (PIX_W'(active) < grid) ? PIX_W'(active) : grid;
    idx = p[SCALED_W-1:FRAC_W];
    return {!p[SCALED_W-1] && (idx < lim), idx};
  endfunction

  always_comb begin
    run_idx = item_i.start_of_run ? '0 : items_q;
    items_d = items_q;
    if (accept_i && !item_i.mode) begin
      items_d = (run_idx == WARM_MAX) ? WARM_MAX : run_idx + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q <= '0;
    end else begin
      items_q <= items_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      is_read_q  <= item_i.mode;
      keep_q     <= (run_idx >= cfg_i.warmup_items);
      prod_x_q   <= item_i.point_x * $signed({1'b0, cfg_i.view_scale});
      prod_y_q   <= item_i.point_y * $signed({1'b0, cfg_i.view_scale});
      color_q    <= (item_i.color_index > ONE_Q16) ? ONE_Q16 : item_i.color_index;
      read_col_q <= item_i.read_col;
      read_row_q <= item_i.read_row;
    end
  end

  always_comb begin
    x_pix = to_pixel(prod_x_q, cfg_i.offset_col, cfg_i.active_width, PIX_W'(GRID_WIDTH));
    y_pix = to_pixel(prod_y_q, cfg_i.offset_row, cfg_i.active_height, PIX_W'(GRID_HEIGHT));
    read_in_grid = (PIX_W'(read_col_q) < PIX_W'(GRID_WIDTH)) &&
                   (PIX_W'(read_row_q) < PIX_W'(GRID_HEIGHT));
    col_sel = is_read_q ? PIX_W'(read_col_q) : x_pix[PIX_W-1:0];
    row_sel = is_read_q ? PIX_W'(read_row_q) : y_pix[PIX_W-1:0];

    map_o.is_read  = is_read_q;
    map_o.plot_hit = !is_read_q && keep_q && x_pix[PIX_W] && y_pix[PIX_W];
    map_o.in_grid  = read_in_grid;
    map_o.color    = color_q;
  end

  // address of an off-grid read is don't-care, the result is masked later
  assign addr_o = ADDR_W'(ADDR_W'(row_sel[ROW_W-1:0]) * ADDR_W'(GRID_WIDTH))
                + ADDR_W'(col_sel[COL_W-1:0]);

endmodule

// ----- hw/rtl/flh_bin_store.sv -----
// -----------------------------------------------------------------------------
// flh_bin_store: histogram bin memory
// One synchronous RAM holding red, green, blue sums and the hit count per
// bin. Read-modify-write with saturating adds; zeroing sweep after reset.
// -----------------------------------------------------------------------------
module flh_bin_store import flh_pkg::*; #(
  parameter int CELLS    = 262144,
  parameter int ADDR_W   = 18,
  parameter int SUM_BITS = 40,
  parameter int HIT_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bin_req_t            req_i,
  input  logic [ADDR_W-1:0]   addr_i,
  output logic                busy_o,
  output logic [SUM_BITS-1:0] red_o,
  output logic [SUM_BITS-1:0] green_o,
  output logic [SUM_BITS-1:0] blue_o,
  output logic [HIT_BITS-1:0] hit_o
);

  localparam int ENTRY_W = 3 * SUM_BITS + HIT_BITS;

  logic [ENTRY_W-1:0] mem [CELLS];
  logic [ENTRY_W-1:0] rdata_q;

  logic                busy_q;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                pend_wr_q;
  logic [ADDR_W-1:0]   pend_addr_q;
  logic [COLOR_W-1:0]  pend_color_q;

  logic                we;
  logic [ADDR_W-1:0]   wa;
  logic [ENTRY_W-1:0]  wd;
  logic [SUM_BITS-1:0] red_new, green_new, blue_new;
  logic [HIT_BITS-1:0] hit_new;

  function automatic logic [SUM_BITS-1:0] sat_sum(
    input logic [SUM_BITS-1:0] old,
    input logic [COLOR_W-1:0]  add
  );
    logic [SUM_BITS:0] s;
    s = {1'b0, old} + (SUM_BITS+1)'(add);
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

  assign red_o   = rdata_q[ENTRY_W-1 -: SUM_BITS];
  assign green_o = rdata_q[ENTRY_W-SUM_BITS-1 -: SUM_BITS];
  assign blue_o  = rdata_q[HIT_BITS +: SUM_BITS];
  assign hit_o   = rdata_q[HIT_BITS-1:0];
  assign busy_o  = busy_q;

  always_comb begin
    red_new   = sat_sum(red_o, ONE_Q16 - pend_color_q);
    green_new = sat_sum(green_o, ONE_Q16 - (pend_color_q >> 1));
    blue_new  = sat_sum(blue_o, ONE_Q16);
    hit_new   = (hit_o == '1) ? hit_o : hit_o + HIT_BITS'(1);

    we = 1'b0;
    wa = pend_addr_q;
    wd = {red_new, green_new, blue_new, hit_new};
    if (busy_q) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = '0;
    end else if (pend_wr_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
      pend_wr_q <= 1'b0;
    end else begin
      pend_wr_q <= req_i.rd && req_i.wr;
      if (busy_q) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(CELLS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      pend_addr_q  <= addr_i;
      pend_color_q <= req_i.color;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (req_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

endmodule

// ----- hw/rtl/flame_histogram_plotter.sv -----
// -----------------------------------------------------------------------------
// flame_histogram_plotter: histogram stage of a fractal flame renderer
// Maps plot points to bins and accumulates colour and hits; reads bins back.
// -----------------------------------------------------------------------------
// Sequence: an item is taken only in idle, then passes accept, address + bin read
//   and bin update before the next is taken; the read-modify-write of the single-port
//   bin RAM sets this, and a read also waits in bin update while the output is full.
// Read results: loaded into the output register after the bin read, later while the
//   previous result still waits there (input held meanwhile). Reset: registers return
//   to defaults, then a zeroing sweep runs over all GRID_WIDTH*GRID_HEIGHT bins with
//   no items taken; configuration writes are taken throughout.
module flame_histogram_plotter import flh_pkg::*; #(
  parameter int GRID_WIDTH  = 512,
  parameter int GRID_HEIGHT = 512,
  parameter int SUM_BITS    = 40,
  parameter int HIT_BITS    = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  flh_item_if.sink     item_i,
  flh_result_if.source result_o,
  flh_cfg_if.sink      cfg_i
);

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  result_t out_data_q, res_d;
  logic    load_out;
  logic    accept;

  cfg_t              cfg;
  map_t              map;
  bin_req_t          req;
  logic [ADDR_W-1:0] addr;
  logic              busy;

  logic [SUM_BITS-1:0] red, green, blue;
  logic [HIT_BITS-1:0] hit;
  logic [63:0]         red_w, green_w, blue_w;
  logic [31:0]         hit_w;

  assign item_i.ready   = (state_q == ST_IDLE);
  assign accept         = item_i.valid && item_i.ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  flh_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  flh_mapper #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .ADDR_W      (ADDR_W)
  ) u_mapper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i.data),
    .cfg_i    (cfg),
    .map_o    (map),
    .addr_o   (addr)
  );

  flh_bin_store #(
    .CELLS    (CELLS),
    .ADDR_W   (ADDR_W),
    .SUM_BITS (SUM_BITS),
    .HIT_BITS (HIT_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .addr_i  (addr),
    .busy_o  (busy),
    .red_o   (red),
    .green_o (green),
    .blue_o  (blue),
    .hit_o   (hit)
  );

  always_comb begin
    state_d  = state_q;
    req      = '0;
    load_out = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (!busy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_MAP;
      end
      ST_MAP: begin
        req.rd    = 1'b1;
        req.wr    = map.plot_hit;
        req.color = map.color;
        state_d   = ST_UPDATE;
      end
      ST_UPDATE: begin
        // plots write back in this cycle inside the store; reads wait for the slot
        if (!map.is_read) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    red_w   = 64'(red);
    green_w = 64'(green);
    blue_w  = 64'(blue);
    hit_w   = 32'(hit);
    res_d.red_sum   = map.in_grid ? red_w[OUT_SUM_W-1:0]   : '0;
    res_d.green_sum = map.in_grid ? green_w[OUT_SUM_W-1:0] : '0;
    res_d.blue_sum  = map.in_grid ? blue_w[OUT_SUM_W-1:0]  : '0;
    res_d.hit_count = map.in_grid ? hit_w[OUT_HIT_W-1:0]   : '0;

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= res_d;
    end
  end

endmodule

// ----- sim/flame_histogram_plotter_tb.sv -----
// -----------------------------------------------------------------------------
// flame_histogram_plotter_tb: self-checking bench for the histogram plotter
// Drives plot and read beats with random gaps and back-pressure, predicts every
// bin in a sparse shadow store and checks each read result against it, across
// several register settings including the extremes.
// -----------------------------------------------------------------------------
module flame_histogram_plotter_tb;
  import flh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_W = 512;
  localparam int GRID_H = 512;
  localparam bit [63:0] SUM_LIMIT = (64'd1 << 40) - 1;
  localparam bit [63:0] HIT_LIMIT = (64'd1 << 24) - 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  // the zeroing sweep after reset takes no items, so it counts as quiet time
  localparam int QUIET_LIMIT = 1000000;

  // shadow of the bin store, register file and warm-up position
  class bin_scoreboard;
    cfg_t regs;
    logic [WARM_W-1:0] run_pos;
    bit [63:0] red_acc[int];
    bit [63:0] green_acc[int];
    bit [63:0] blue_acc[int];
    bit [63:0] hit_acc[int];
    int touched[$];
    result_t pending_reads[$];
    int errors;
    int plot_beats;
    int landed;
    int reads_checked;
    int reg_writes;

    function new();
      regs.active_width  = RST_ACTIVE_WIDTH;
      regs.active_height = RST_ACTIVE_HEIGHT;
      regs.view_scale    = RST_VIEW_SCALE;
      regs.offset_col    = RST_OFFSET_COL;
      regs.offset_row    = RST_OFFSET_ROW;
      regs.warmup_items  = RST_WARMUP_ITEMS;
      run_pos = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wd);
      reg_writes++;
      case (idx)
        CFG_ACTIVE_WIDTH:  regs.active_width  = wd[FIELD_W-1:0];
        CFG_ACTIVE_HEIGHT: regs.active_height = wd[FIELD_W-1:0];
        CFG_VIEW_SCALE:    regs.view_scale    = wd[FIELD_W-1:0];
        CFG_OFFSET_COL:    regs.offset_col    = wd[FIELD_W-1:0];
        CFG_OFFSET_ROW:    regs.offset_row    = wd[FIELD_W-1:0];
        CFG_WARMUP_ITEMS:  regs.warmup_items  = wd[WARM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit to_pix(logic signed [POINT_W-1:0] raw, logic [FIELD_W-1:0] off,
                        logic [FIELD_W-1:0] active, int grid, output int pix);
      longint sx;
      longint p;
      longint lim;
      sx = raw;
      p = sx * longint'(regs.view_scale) + (longint'(off) <<< FRAC_W);
      lim = (int'(active) < grid) ? int'(active) : grid;
      pix = 0;
      if (p < 0) return 0;
      if ((p >>> FRAC_W) >= lim) return 0;
      pix = int'(p >>> FRAC_W);
      return 1;
    endfunction

    function bit [63:0] sat_add(bit [63:0] old, bit [63:0] add, bit [63:0] max);
      if (old > max) old = max;
      if (max - old < add) return max;
      return old + add;
    endfunction

    function void take_item(item_t it);
      int col;
      int row;
      int addr;
      logic [WARM_W-1:0] pos;
      logic [COLOR_W-1:0] c;
      result_t r;
      if (it.mode) begin
        addr = int'(it.read_row) * GRID_W + int'(it.read_col);
        r = '0;
        if (hit_acc.exists(addr)) begin
          r.red_sum   = OUT_SUM_W'(red_acc[addr]);
          r.green_sum = OUT_SUM_W'(green_acc[addr]);
          r.blue_sum  = OUT_SUM_W'(blue_acc[addr]);
          r.hit_count = OUT_HIT_W'(hit_acc[addr]);
        end
        pending_reads = {pending_reads, r};
        return;
      end
      plot_beats++;
      pos = it.start_of_run ? '0 : run_pos;
      run_pos = (pos == WARM_MAX) ? WARM_MAX : pos + WARM_W'(1);
      if (pos < regs.warmup_items) return;
      if (!to_pix(it.point_x, regs.offset_col, regs.active_width, GRID_W, col)) return;
      if (!to_pix(it.point_y, regs.offset_row, regs.active_height, GRID_H, row)) return;
      addr = row * GRID_W + col;
      c = (it.color_index > ONE_Q16) ? ONE_Q16 : it.color_index;
      if (!hit_acc.exists(addr)) begin
        touched = {touched, addr};
        red_acc[addr] = 0;
        green_acc[addr] = 0;
        blue_acc[addr] = 0;
        hit_acc[addr] = 0;
      end
      red_acc[addr]   = sat_add(red_acc[addr], 64'(ONE_Q16 - c), SUM_LIMIT);
      green_acc[addr] = sat_add(green_acc[addr], 64'(ONE_Q16 - (c >> 1)), SUM_LIMIT);
      blue_acc[addr]  = sat_add(blue_acc[addr], 64'(ONE_Q16), SUM_LIMIT);
      hit_acc[addr]   = sat_add(hit_acc[addr], 64'd1, HIT_LIMIT);
      landed++;
    endfunction

    function void report(string what, result_t want, result_t got);
      errors++;
      if (errors <= 10)
        $display({"ERROR %s: expected red %0h green %0h blue %0h hits %0d,",
                  " got red %0h green %0h blue %0h hits %0d"},
                 what, want.red_sum, want.green_sum, want.blue_sum, want.hit_count,
                 got.red_sum, got.green_sum, got.blue_sum, got.hit_count);
    endfunction

    function void check_read(result_t got);
      result_t want;
      if (pending_reads.size() == 0) begin
        report("result beat with no read outstanding", '0, got);
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got.red_sum !== want.red_sum || got.green_sum !== want.green_sum ||
          got.blue_sum !== want.blue_sum || got.hit_count !== want.hit_count)
        report($sformatf("bin read %0d", reads_checked), want, got);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  flh_item_if   item_if ();
  flh_result_if res_if ();
  flh_cfg_if    cfg_if ();

  flame_histogram_plotter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  bin_scoreboard sb;
  bit calm;
  bit hold_req;
  int hot_col[4];
  int hot_row[4];
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int idle_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // usable extent of one axis, never below one pixel
  function automatic int axis_span(int active, int grid);
    int s;
    s = (active < grid) ? active : grid;
    return (s < 1) ? 1 : s;
  endfunction

  // coordinate that lands near a wanted pixel under the current transform
  function automatic logic signed [POINT_W-1:0] aim(int target, int off, int scale);
    longint v;
    if (scale == 0) return POINT_W'($urandom);
    v = (longint'(target - off) * 65536) / scale + $urandom_range(0, 15);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[POINT_W-1:0];
  endfunction

  function automatic item_t make_item(bit mode, bit sor, int x, int y, int c, int col, int row);
    item_t it;
    it.mode = mode;
    it.start_of_run = sor;
    it.point_x = POINT_W'(x);
    it.point_y = POINT_W'(y);
    it.color_index = COLOR_W'(c);
    it.read_col = RD_W'(col);
    it.read_row = RD_W'(row);
    return it;
  endfunction

  function automatic item_t random_item(int sor_pct);
    item_t it;
    int k;
    int h;
    int addr;
    int tgt;
    it.mode = ($urandom_range(0, 99) < 30);
    it.start_of_run = it.mode ? 1'($urandom_range(0, 1)) :
                      ($urandom_range(0, 99) < sor_pct);
    it.point_x = POINT_W'($urandom);
    it.point_y = POINT_W'($urandom);
    it.color_index = COLOR_W'($urandom);
    it.read_col = RD_W'($urandom);
    it.read_row = RD_W'($urandom);
    if (it.mode) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        h = $urandom_range(0, 3);
        it.read_col = RD_W'(hot_col[h]);
        it.read_row = RD_W'(hot_row[h]);
      end else if (k < 75 && sb.touched.size() > 0) begin
        addr = sb.touched[$urandom_range(0, sb.touched.size() - 1)];
        it.read_col = RD_W'(addr % GRID_W);
        it.read_row = RD_W'(addr / GRID_W);
      end
      return it;
    end
    if ($urandom_range(0, 99) >= 15) begin
      tgt = ($urandom_range(0, 99) < 60) ? hot_col[$urandom_range(0, 3)] :
            $urandom_range(0, axis_span(sb.regs.active_width, GRID_W) + 3);
      it.point_x = aim(tgt, sb.regs.offset_col, sb.regs.view_scale);
    end
    if ($urandom_range(0, 99) >= 15) begin
      tgt = ($urandom_range(0, 99) < 60) ? hot_row[$urandom_range(0, 3)] :
            $urandom_range(0, axis_span(sb.regs.active_height, GRID_H) + 3);
      it.point_y = aim(tgt, sb.regs.offset_row, sb.regs.view_scale);
    end
    k = $urandom_range(0, 99);
    if (k >= 10) it.color_index = (k < 20) ? ONE_Q16 : COLOR_W'($urandom_range(0, 65536));
    return it;
  endfunction

  // entered and left at a falling edge; valid stays high across back-to-back beats
  task automatic send_item(input item_t it);
    int g;
    g = calm ? 0 : idle_len();
    if (g > 0) begin
      item_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    item_if.valid = 1'b1;
    item_if.data = it;
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input int value);
    logic [CFG_DATA_W-1:0] junk;
    // junk above the register width must be masked off by the block
    junk = (idx == CFG_WARMUP_ITEMS) ? 16'hFF00 : 16'hFC00;
    cfg_if.data.idx = idx;
    cfg_if.data.wdata = CFG_DATA_W'(value) | (CFG_DATA_W'($urandom) & junk);
    cfg_if.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // plots give no result, so allow the pipeline to empty after the last read
  task automatic drain();
    item_if.valid = 1'b0;
    while (sb.pending_reads.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input int w, input int h, input int s, input int oc,
                           input int orow, input int warm, input int n,
                           input int sor_pct, input bit quiet, input bit squeeze);
    int span_c;
    int span_r;
    drain();
    set_reg(CFG_ACTIVE_WIDTH, w);
    set_reg(CFG_ACTIVE_HEIGHT, h);
    set_reg(CFG_VIEW_SCALE, s);
    set_reg(CFG_OFFSET_COL, oc);
    set_reg(CFG_OFFSET_ROW, orow);
    set_reg(CFG_WARMUP_ITEMS, warm);
    span_c = axis_span(w, GRID_W);
    span_r = axis_span(h, GRID_H);
    // two hot pixels sit on the grid edges, all four take a large share of the traffic
    hot_col[0] = span_c - 1;
    hot_row[0] = span_r - 1;
    hot_col[1] = 0;
    hot_row[1] = 0;
    for (int i = 2; i < 4; i++) begin
      hot_col[i] = $urandom_range(0, span_c - 1);
      hot_row[i] = $urandom_range(0, span_r - 1);
    end
    calm = quiet;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == 40) hold_req = 1'b1;
      send_item(random_item(sor_pct));
    end
    calm = 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int stall;
    stall = 0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (calm) begin
        res_if.ready = 1'b1;
      end else if (stall > 0) begin
        res_if.ready = 1'b0;
        stall--;
      end else begin
        res_if.ready = 1'b1;
        if ($urandom_range(0, 99) < 20) stall = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.data.idx, cfg_if.data.wdata);
      if (res_if.valid && res_if.ready) sb.check_read(res_if.data);
      if (item_if.valid && item_if.ready) sb.take_item(item_if.data);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet_cycles);
      $display("flame_histogram_plotter regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    item_if.valid = 1'b0;
    item_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: other registers stay at their reset values, short warm-up
    set_reg(CFG_WARMUP_ITEMS, 2);
    send_item(make_item(0, 1, 0, 0, 0, 0, 0));            // first of run, warm-up
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));            // still warm-up
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));            // lands at 500,500
    send_item(make_item(0, 0, 0, 0, 65536, 0, 0));
    send_item(make_item(0, 0, 0, 0, 131071, 0, 0));       // colour above one
    send_item(make_item(0, 0, 0, 0, 1, 0, 0));            // odd colour, green truncates
    send_item(make_item(1, 0, 0, 0, 0, 500, 500));        // read straight after updates
    send_item(make_item(0, 0, -81920, -81920, 12345, 0, 0)); // exactly pixel 0,0
    send_item(make_item(0, 0, -81921, 0, 0, 0, 0));       // just below zero
    send_item(make_item(0, 0, 524287, 0, 0, 0, 0));
    send_item(make_item(0, 0, 0, -524288, 0, 0, 0));
    send_item(make_item(0, 0, -524288, 524287, 0, 0, 0));
    send_item(make_item(0, 0, 1803, 1803, 777, 0, 0));    // last column and row
    send_item(make_item(0, 0, 1967, 0, 0, 0, 0));         // one past the last column
    send_item(make_item(1, 1, 0, 0, 0, 0, 0));            // read must not restart the run
    send_item(make_item(0, 0, 0, 0, 40000, 0, 0));
    send_item(make_item(1, 0, 0, 0, 0, 500, 500));
    send_item(make_item(1, 0, 0, 0, 0, 511, 511));
    send_item(make_item(0, 1, 0, 0, 0, 0, 0));            // new run, back in warm-up
    send_item(make_item(1, 0, 0, 0, 0, 500, 500));
    send_item(make_item(1, 0, 0, 0, 0, 511, 0));          // never hit

    run_phase(512, 512, 400, 500, 500, 21, 250, 2, 1'b0, 1'b0);
    run_phase(1, 1, 0, 0, 0, 0, 200, 2, 1'b1, 1'b0);         // every point on one bin
    run_phase(1023, 1023, 1023, 1023, 1023, 255, 450, 0, 1'b0, 1'b0); // warm-up saturates
    run_phase(0, 300, 123, 256, 17, 5, 150, 2, 1'b0, 1'b0);  // zero width
    run_phase(200, 0, 64, 100, 100, 3, 100, 2, 1'b0, 1'b0);  // zero height
    run_phase($urandom_range(1, 512), $urandom_range(1, 512), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 40),
              200, 3, 1'b0, 1'b1);
    run_phase($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255),
              200, 1, 1'b0, 1'b0);
    drain();

    $display("Covered %0d plot beats (%0d landed in %0d bins) and %0d checked bin reads,",
             sb.plot_beats, sb.landed, sb.touched.size(), sb.reads_checked);
    $display("over %0d register writes; %0d mismatches.", sb.reg_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("flame_histogram_plotter regression: pass");
    end else begin
      $display("flame_histogram_plotter regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/flh_pkg.sv
hw/rtl/flh_item_if.sv
hw/rtl/flh_result_if.sv
hw/rtl/flh_cfg_if.sv
hw/rtl/flh_cfg_regs.sv
hw/rtl/flh_mapper.sv
hw/rtl/flh_bin_store.sv
hw/rtl/flame_histogram_plotter.sv
sim/flame_histogram_plotter_tb.sv
